FILE: sv/itdbm_pkg.sv
// Shared constants, types and helper functions of the ITD binary mask filter.
`timescale 1ns / 1ps
`default_nettype none

package itdbm_pkg;

  // Transform size and sample format
  localparam int FFT_LEN  = 512;
  localparam int HALF_LEN = FFT_LEN / 2;
  localparam int FFT_LOG  = $clog2(FFT_LEN);
  localparam int SAMPLE_W = 16;
  localparam int BIN_W    = 9;

  // Register formats
  localparam int THR_W  = 16;
  localparam int MASK_W = 17;
  localparam int CFG_W  = 17;
  localparam logic [MASK_W-1:0] ONE_Q16 = MASK_W'(65536);
  localparam logic [MASK_W-1:0] HALF_Q16 = MASK_W'(32768);

  // Threshold reset values
  localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(9637);
  localparam logic [MASK_W-1:0] FLOOR_RESET = MASK_W'(6554);

  // Delay test: d*FFT_LEN*2^10 <= thr*k*2^16 reduces to d*FFT_LEN <= thr*k*2^6
  localparam int THR_SHIFT = 6;
  localparam int CMP_W     = THR_W + BIN_W + THR_SHIFT + 1;

  // CORDIC format: samples scaled by 2^16 with headroom for the gain
  localparam int ANG_W      = 16;
  localparam int ITERS      = 16;
  localparam int ITER_W     = $clog2(ITERS);
  localparam int PRE_SHIFT  = 16;
  localparam int CW         = SAMPLE_W + PRE_SHIFT + 3;
  localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(32768);

  // Mask update and scaling widths
  localparam int ACC_W  = 2 * MASK_W + 2;
  localparam int PROD_W = SAMPLE_W + MASK_W + 1;

  // Stream word widths
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 48;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHANNEL_SELECT = 2'd0,
    CFG_ITD_THRESHOLD  = 2'd1,
    CFG_FORGET_FACTOR  = 2'd2,
    CFG_FLOOR_GAIN     = 2'd3
  } cfg_idx_t;

  // Arctangent of 2^-i in binary angle units
  function automatic logic [ANG_W-1:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      4'd0:    a = 16'd8192;
      4'd1:    a = 16'd4836;
      4'd2:    a = 16'd2555;
      4'd3:    a = 16'd1297;
      4'd4:    a = 16'd651;
      4'd5:    a = 16'd326;
      4'd6:    a = 16'd163;
      4'd7:    a = 16'd81;
      4'd8:    a = 16'd41;
      4'd9:    a = 16'd20;
      4'd10:   a = 16'd10;
      4'd11:   a = 16'd5;
      4'd12:   a = 16'd3;
      4'd13:   a = 16'd1;
      4'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  // Clamp a wide value to the sample range
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'((1 <<< (SAMPLE_W - 1)) - 1);
    lo = -hi - PROD_W'(1);
    if (v > hi) return hi[SAMPLE_W-1:0];
    if (v < lo) return lo[SAMPLE_W-1:0];
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/itd_binary_mask_filter_top.sv
// Top level of the ITD binary mask filter: CORDIC phase pipeline and mask memory.
`timescale 1ns / 1ps
`default_nettype none

// One frequency bin enters per word; bins 1 to FFT_LEN/2-1 give two result words
// (bin k, then the conjugate at FFT_LEN-k), bin 0 and the Nyquist bin give one,
// and bins above FFT_LEN/2 give none. The single result port sets the rate: a
// two-result bin holds the pipeline until its second word is taken, others do not.
// From the accepting edge a bin passes an input register, a pre-rotation
// stage, a 16-stage CORDIC for both channels, a delay-test stage, a mask
// read-modify-write stage on a simple dual-port memory with forwarding between
// neighbors, two scaling stages and the output register. After reset a clearing
// pass over all FFT_LEN/2+1 = 257 addresses sets every stored mask to one; no bin is
// accepted during it, configuration writes are.
module itd_binary_mask_filter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [itdbm_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // bin_index, left_real, left_imag, right_real, right_imag, zero fill
  input  logic [itdbm_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // out_bin, out_real, out_imag, zero fill
  output logic [itdbm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                             m_tlast
);

  localparam int SW = itdbm_pkg::SAMPLE_W;
  localparam int BW = itdbm_pkg::BIN_W;
  localparam int CW = itdbm_pkg::CW;
  localparam int AW = itdbm_pkg::ANG_W;
  localparam int MW = itdbm_pkg::MASK_W;
  localparam int NI = itdbm_pkg::ITERS;
  localparam int PW = itdbm_pkg::PROD_W;
  localparam int XW = CW - SW - itdbm_pkg::PRE_SHIFT;

  // Configuration registers
  logic                         channel_select;
  logic [itdbm_pkg::THR_W-1:0]  itd_threshold;
  logic [MW-1:0]                forget_factor;
  logic [MW-1:0]                floor_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= 1'b0;
      itd_threshold  <= itdbm_pkg::THR_RESET;
      forget_factor  <= '0;
      floor_gain     <= itdbm_pkg::FLOOR_RESET;
    end else if (cfg_we) begin
      case (itdbm_pkg::cfg_idx_t'(cfg_index))
        itdbm_pkg::CFG_CHANNEL_SELECT: channel_select <= cfg_data[0];
        itdbm_pkg::CFG_ITD_THRESHOLD:  itd_threshold  <= cfg_data[itdbm_pkg::THR_W-1:0];
        itdbm_pkg::CFG_FORGET_FACTOR:  forget_factor  <= cfg_data[MW-1:0];
        itdbm_pkg::CFG_FLOOR_GAIN:     floor_gain     <= cfg_data[MW-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass over the mask memory
  logic          clr_busy;
  logic [BW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + BW'(1);
      if (clr_addr == BW'(itdbm_pkg::HALF_LEN)) clr_busy <= 1'b0;
    end
  end

  // Pipeline advance and output register handshake
  logic adv;
  logic oload;
  logic prd_v;
  logic ov;
  logic obeat;
  logic otwo;

  assign oload    = !ov || (m_tready && (obeat || !otwo));
  assign adv      = !prd_v || oload;
  assign s_tready = adv && !clr_busy;

  // Input stage
  logic                 in_v;
  logic [BW-1:0]        in_k;
  logic signed [SW-1:0] in_lr, in_li, in_rr, in_ri;
  logic                 in_ok;

  assign in_ok = s_tvalid && s_tready &&
                 (s_tdata[BW-1:0] <= BW'(itdbm_pkg::HALF_LEN));

  always_ff @(posedge clk) begin
    if (adv) begin
      in_k  <= in_ok ? s_tdata[BW-1:0] : '0;
      in_lr <= s_tdata[BW+SW-1:BW];
      in_li <= s_tdata[BW+2*SW-1:BW+SW];
      in_rr <= s_tdata[BW+3*SW-1:BW+2*SW];
      in_ri <= s_tdata[BW+4*SW-1:BW+3*SW];
    end
  end

  // Pre-rotate vectors in the left half plane by half a turn
  logic signed [CW-1:0] pre_xl, pre_yl, pre_xr, pre_yr;
  logic [AW-1:0]        pre_zl, pre_zr;
  logic signed [CW-1:0] ext_lr, ext_li, ext_rr, ext_ri;

  always_comb begin
    ext_lr = {{XW{in_lr[SW-1]}}, in_lr, {itdbm_pkg::PRE_SHIFT{1'b0}}};
    ext_li = {{XW{in_li[SW-1]}}, in_li, {itdbm_pkg::PRE_SHIFT{1'b0}}};
    ext_rr = {{XW{in_rr[SW-1]}}, in_rr, {itdbm_pkg::PRE_SHIFT{1'b0}}};
    ext_ri = {{XW{in_ri[SW-1]}}, in_ri, {itdbm_pkg::PRE_SHIFT{1'b0}}};
    pre_xl = in_lr[SW-1] ? -ext_lr : ext_lr;
    pre_yl = in_lr[SW-1] ? -ext_li : ext_li;
    pre_zl = in_lr[SW-1] ? itdbm_pkg::HALF_TURN : '0;
    pre_xr = in_rr[SW-1] ? -ext_rr : ext_rr;
    pre_yr = in_rr[SW-1] ? -ext_ri : ext_ri;
    pre_zr = in_rr[SW-1] ? itdbm_pkg::HALF_TURN : '0;
  end

  // CORDIC vectoring pipeline, one iteration per stage for both channels
  logic                 c_v  [0:NI];
  logic [BW-1:0]        c_k  [0:NI];
  logic signed [SW-1:0] c_xr [0:NI];
  logic signed [SW-1:0] c_xi [0:NI];
  logic                 c_zl [0:NI];
  logic                 c_zr [0:NI];
  logic signed [CW-1:0] cx_l [0:NI];
  logic signed [CW-1:0] cy_l [0:NI];
  logic [AW-1:0]        cz_l [0:NI];
  logic signed [CW-1:0] cx_r [0:NI];
  logic signed [CW-1:0] cy_r [0:NI];
  logic [AW-1:0]        cz_r [0:NI];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NI; j++) c_v[j] <= 1'b0;
    end else if (adv) begin
      c_v[0] <= in_v;
      for (int j = 0; j < NI; j++) c_v[j+1] <= c_v[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_k[0]  <= in_k;
      // Bin zero always passes the left channel
      c_xr[0] <= (channel_select && (in_k != '0)) ? in_rr : in_lr;
      c_xi[0] <= (channel_select && (in_k != '0)) ? in_ri : in_li;
      c_zl[0] <= (in_lr == '0) && (in_li == '0);
      c_zr[0] <= (in_rr == '0) && (in_ri == '0);
      cx_l[0] <= pre_xl;
      cy_l[0] <= pre_yl;
      cz_l[0] <= pre_zl;
      cx_r[0] <= pre_xr;
      cy_r[0] <= pre_yr;
      cz_r[0] <= pre_zr;
      for (int j = 0; j < NI; j++) begin
        c_k[j+1]  <= c_k[j];
        c_xr[j+1] <= c_xr[j];
        c_xi[j+1] <= c_xi[j];
        c_zl[j+1] <= c_zl[j];
        c_zr[j+1] <= c_zr[j];
        // Rotate toward the x axis: clockwise when y is not negative
        cx_l[j+1] <= cy_l[j][CW-1] ? cx_l[j] - (cy_l[j] >>> j) : cx_l[j] + (cy_l[j] >>> j);
        cy_l[j+1] <= cy_l[j][CW-1] ? cy_l[j] + (cx_l[j] >>> j) : cy_l[j] - (cx_l[j] >>> j);
        cz_l[j+1] <= cy_l[j][CW-1] ? cz_l[j] - itdbm_pkg::atan_turn(j[itdbm_pkg::ITER_W-1:0])
                                   : cz_l[j] + itdbm_pkg::atan_turn(j[itdbm_pkg::ITER_W-1:0]);
        cx_r[j+1] <= cy_r[j][CW-1] ? cx_r[j] - (cy_r[j] >>> j) : cx_r[j] + (cy_r[j] >>> j);
        cy_r[j+1] <= cy_r[j][CW-1] ? cy_r[j] + (cx_r[j] >>> j) : cy_r[j] - (cx_r[j] >>> j);
        cz_r[j+1] <= cy_r[j][CW-1] ? cz_r[j] - itdbm_pkg::atan_turn(j[itdbm_pkg::ITER_W-1:0])
                                   : cz_r[j] + itdbm_pkg::atan_turn(j[itdbm_pkg::ITER_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else if (adv) in_v <= in_ok;
  end

  // Delay test: fold the phase difference into half a turn, compare without dividing
  logic [AW-1:0]               ang_l, ang_r, dphi;
  logic [AW:0]                 dfold;
  logic [itdbm_pkg::CMP_W-1:0] lhs, rhs;
  logic                        near;

  always_comb begin
    ang_l = c_zl[NI] ? '0 : cz_l[NI];
    ang_r = c_zr[NI] ? '0 : cz_r[NI];
    dphi  = ang_l - ang_r;
    dfold = (dphi > itdbm_pkg::HALF_TURN) ? (AW+1)'(1 << AW) - {1'b0, dphi} : {1'b0, dphi};
    lhs   = itdbm_pkg::CMP_W'(dfold) << itdbm_pkg::FFT_LOG;
    rhs   = (itdbm_pkg::CMP_W'(itd_threshold) * itdbm_pkg::CMP_W'(c_k[NI]))
            << itdbm_pkg::THR_SHIFT;
    near  = lhs <= rhs;
  end

  logic                 dly_v;
  logic [BW-1:0]        dly_k;
  logic signed [SW-1:0] dly_xr, dly_xi;
  logic                 dly_near;

  always_ff @(posedge clk) begin
    if (rst) dly_v <= 1'b0;
    else if (adv) dly_v <= c_v[NI];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_k    <= c_k[NI];
      dly_xr   <= c_xr[NI];
      dly_xi   <= c_xi[NI];
      dly_near <= near;
    end
  end

  // Mask stage: the stored mask is read into a register together with the bin
  logic                 msk_v;
  logic [BW-1:0]        msk_k;
  logic signed [SW-1:0] msk_xr, msk_xi;
  logic                 msk_near;
  logic [MW-1:0]        mask_rd;
  logic                 msk_wr;
  logic [MW-1:0]        mu;

  logic [MW-1:0] mask_mem [0:itdbm_pkg::HALF_LEN];

  assign msk_wr = msk_v && (msk_k != '0);

  // Clear, write back the new mask and read the next bin's mask
  always_ff @(posedge clk) begin
    if (clr_busy) mask_mem[clr_addr] <= itdbm_pkg::ONE_Q16;
    else if (adv && msk_wr) mask_mem[msk_k] <= mu;
    if (adv) mask_rd <= mask_mem[dly_k];
  end

  always_ff @(posedge clk) begin
    if (rst) msk_v <= 1'b0;
    else if (adv) msk_v <= dly_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      msk_k    <= dly_k;
      msk_xr   <= dly_xr;
      msk_xi   <= dly_xi;
      msk_near <= dly_near;
    end
  end

  // Forward the write made as this bin was read
  logic          fwd_v;
  logic [BW-1:0] fwd_k;
  logic [MW-1:0] fwd_mu;

  always_ff @(posedge clk) begin
    if (rst) fwd_v <= 1'b0;
    else if (adv) fwd_v <= msk_wr;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_k  <= msk_k;
      fwd_mu <= mu;
    end
  end

  // Smooth: mu = target + alpha*(prev - target), rounded and limited to one; bin zero stays at one
  logic [MW-1:0]                   alpha, eta, target, prev;
  logic signed [MW:0]              diff;
  logic signed [itdbm_pkg::ACC_W-1:0] prod, acc;
  logic [itdbm_pkg::ACC_W-1:0]     mu_wide;

  always_comb begin
    alpha   = (forget_factor > itdbm_pkg::ONE_Q16) ? itdbm_pkg::ONE_Q16 : forget_factor;
    eta     = (floor_gain > itdbm_pkg::ONE_Q16) ? itdbm_pkg::ONE_Q16 : floor_gain;
    target  = (msk_near ^ channel_select) ? itdbm_pkg::ONE_Q16 : eta;
    prev    = (fwd_v && (fwd_k == msk_k)) ? fwd_mu : mask_rd;
    diff    = $signed({1'b0, prev}) - $signed({1'b0, target});
    prod    = itdbm_pkg::ACC_W'($signed({1'b0, alpha}) * diff);
    acc     = $signed(itdbm_pkg::ACC_W'({target, 16'b0})) + prod
            + $signed(itdbm_pkg::ACC_W'(itdbm_pkg::HALF_Q16));
    mu_wide = itdbm_pkg::ACC_W'(acc >>> 16);
    if (msk_k == '0) mu = itdbm_pkg::ONE_Q16;
    else if (mu_wide > itdbm_pkg::ACC_W'(itdbm_pkg::ONE_Q16)) mu = itdbm_pkg::ONE_Q16;
    else mu = mu_wide[MW-1:0];
  end

  // Scale stage
  logic                 scl_v;
  logic [BW-1:0]        scl_k;
  logic signed [SW-1:0] scl_xr, scl_xi;
  logic [MW-1:0]        scl_mu;

  always_ff @(posedge clk) begin
    if (rst) scl_v <= 1'b0;
    else if (adv) scl_v <= msk_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      scl_k  <= msk_k;
      scl_xr <= msk_xr;
      scl_xi <= msk_xi;
      scl_mu <= mu;
    end
  end

  // Product stage
  logic [BW-1:0]        prd_k;
  logic signed [PW-1:0] prd_re, prd_im;

  always_ff @(posedge clk) begin
    if (rst) prd_v <= 1'b0;
    else if (adv) prd_v <= scl_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prd_k  <= scl_k;
      prd_re <= PW'(scl_xr * $signed({1'b0, scl_mu}));
      prd_im <= PW'(scl_xi * $signed({1'b0, scl_mu}));
    end
  end

  // Round, saturate and negate for the mirror bin
  logic signed [PW-1:0] rnd_re, rnd_im;
  logic [SW-1:0]        v_re, v_im, v_imn;

  always_comb begin
    rnd_re = (prd_re + PW'(32768)) >>> 16;
    rnd_im = (prd_im + PW'(32768)) >>> 16;
    v_re   = itdbm_pkg::sat_sample(rnd_re);
    v_im   = itdbm_pkg::sat_sample(rnd_im);
    v_imn  = itdbm_pkg::sat_sample(-PW'($signed(v_im)));
  end

  // Output register: one or two words per bin
  logic [BW-1:0] o_k;
  logic [SW-1:0] o_re, o_im, o_imn;
  logic [BW-1:0] o_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov    <= 1'b0;
      obeat <= 1'b0;
    end else if (oload) begin
      ov    <= prd_v;
      obeat <= 1'b0;
    end else if (ov && m_tready) begin
      obeat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (oload) begin
      o_k   <= prd_k;
      o_re  <= v_re;
      o_im  <= v_im;
      o_imn <= v_imn;
      otwo  <= (prd_k != '0) && (prd_k < BW'(itdbm_pkg::HALF_LEN));
    end
  end

  assign o_bin    = obeat ? BW'(itdbm_pkg::FFT_LEN - int'(o_k)) : o_k;
  assign m_tvalid = ov;
  assign m_tlast  = obeat || !otwo;
  assign m_tdata  = itdbm_pkg::OUT_DATA_W'({(obeat ? o_imn : o_im), o_re, o_bin});

  // No bin is taken while the memory is being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !clr_busy)
    else $error("bin accepted during clearing pass");

  // The delay and mask stages hold no bin during clearing
  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!msk_v && !dly_v))
    else $error("mask access during clearing pass");

  // A second word only follows for a bin with a mirror
  a_second_beat: assert property (@(posedge clk) disable iff (rst)
    (ov && obeat) |-> otwo)
    else $error("mirror word for single-result bin");

  // Smoothed mask never exceeds one
  a_mu_range: assert property (@(posedge clk) disable iff (rst)
    scl_v |-> (scl_mu <= itdbm_pkg::ONE_Q16))
    else $error("mask above one");

  // Forwarded writes come from stored bins only
  a_fwd_bin: assert property (@(posedge clk) disable iff (rst)
    fwd_v |-> ((fwd_k != '0) && (fwd_k <= BW'(itdbm_pkg::HALF_LEN))))
    else $error("forwarded write to invalid bin");

endmodule

`default_nettype wire
